### hw/rtl/ibe_pkg.sv
package ibe_pkg;

   // width of the working immediate: a 32-bit value negated, made pc-relative
   // and negated again still fits
   localparam int ImmW = 34;
   localparam int AddrW = 16;

   // mode bit positions
   localparam int MB_PREFIX = 0;
   localparam int MB_LDRR   = 1;
   localparam int MB_REL    = 2;
   localparam int MB_ADDSUB = 3;
   localparam int MB_NEG    = 4;
   localparam int MB_RST    = 5;
   localparam int MB_STOP   = 6;
   localparam int MB_IMM    = 7;

   // immediate kinds
   localparam logic [2:0] KIND_BIT   = 3'd1;
   localparam logic [2:0] KIND_UBYTE = 3'd2;
   localparam logic [2:0] KIND_SBYTE = 3'd3;
   localparam logic [2:0] KIND_UWORD = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_MEM_MEM = 3'd1;
   localparam logic [2:0] ST_IMM_RNG = 3'd2;
   localparam logic [2:0] ST_JMP_RNG = 3'd3;
   localparam logic [2:0] ST_BAD_RST = 3'd4;

   localparam logic [2:0] REG_MEMHL = 3'd6;
   localparam logic [2:0] REG_A     = 3'd7;

   localparam logic [7:0]  OP_SWAP     = 8'h10;
   localparam logic [7:0]  OP_LDH_TO   = 8'hE0;
   localparam logic [7:0]  OP_LDH_FROM = 8'hF0;
   localparam logic [7:0]  OP_PREFIX   = 8'hCB;
   localparam logic [15:0] HIGH_PAGE   = 16'hFF00;
   localparam int          RST_MAX     = 'h38;

   // one instruction on its way down the pipeline
   typedef struct packed {
      logic [7:0]      enc;
      logic [7:0]      mode;
      logic [2:0]      kind;
      logic [2:0]      lnum;
      logic [2:0]      rnum;
      logic [3:0]      lsh;
      logic [3:0]      rsh;
      logic [ImmW-1:0] imm;
      logic [AddrW:0]  addrp2;
      logic            w8;
      logic            w16;
      logic [2:0]      status;
   } stage_type;

   // finished byte list held by the output serialiser
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic [2:0]      status;
   } ser_type;

endpackage

### hw/rtl/instruction_byte_encoder.sv
// channel   ports                                   handshake
// --------  --------------------------------------  ------------------------------
// request   req_* (10 fields)                        taken when start & !busy
// result    rsp_out_byte, rsp_last_byte, rsp_status  one cycle each, rsp_strobe
//
// five register stages: negate, pc-relative, add/sub swap, high page, range
// check and byte assembly into the output serialiser
// a request can enter every cycle while busy is low
// the serialiser sends one byte a cycle, so an instruction of n bytes (1..4)
// holds the pipeline until its last byte is out; busy rises when the pipeline is full
// synchronous active-high reset clears the valid bits and the serialiser
// the receiver cannot stall: every result is taken on its strobe cycle
module instruction_byte_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_base_opcode,
   input  logic [7:0]  req_mode_bits,
   input  logic [2:0]  req_immediate_kind,
   input  logic [2:0]  req_left_register,
   input  logic [2:0]  req_right_register,
   input  logic signed [3:0]  req_left_shift,
   input  logic signed [3:0]  req_right_shift,
   input  logic signed [31:0] req_immediate_value,
   input  logic        req_immediate_negated,
   input  logic [15:0] req_instruction_address,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_byte,
   output logic [2:0]  rsp_status
);

   // valid bits of the four pipeline registers
   logic [4:1] vld_ff;
   logic [4:1] rdy;
   logic       accept;

   ibe_pkg::stage_type st1_ff, st1_in;
   ibe_pkg::stage_type st2_ff, st2_in;
   ibe_pkg::stage_type st3_ff, st3_in;
   ibe_pkg::stage_type st4_ff, st4_in;

   // output serialiser
   logic             ser_valid_ff;
   ibe_pkg::ser_type ser_ff, ser_in;
   logic [1:0]       idx_ff;
   logic             ser_ready;

   // ------------------------------------------------------------------
   // flow control: a stage moves on when the next one is empty or moving
   // ------------------------------------------------------------------
   assign ser_ready = !ser_valid_ff || (idx_ff == ser_ff.last_idx);
   assign rdy[4]    = !vld_ff[4] || ser_ready;
   assign rdy[3]    = !vld_ff[3] || rdy[4];
   assign rdy[2]    = !vld_ff[2] || rdy[3];
   assign rdy[1]    = !vld_ff[1] || rdy[2];
   assign busy      = !rdy[1];
   assign accept    = start && !busy;

   // stage 1: apply the leading minus sign, catch memory-to-memory loads
   always_comb begin
      logic [ibe_pkg::ImmW-1:0] ext;
      ext = {{(ibe_pkg::ImmW-32){req_immediate_value[31]}}, req_immediate_value};
      st1_in.enc    = req_base_opcode;
      st1_in.mode   = req_mode_bits;
      st1_in.kind   = req_immediate_kind;
      st1_in.lnum   = req_left_register;
      st1_in.rnum   = req_right_register;
      st1_in.lsh    = req_left_shift;
      st1_in.rsh    = req_right_shift;
      st1_in.imm    = req_immediate_negated ? (ibe_pkg::ImmW'(0) - ext) : ext;
      st1_in.addrp2 = {1'b0, req_instruction_address} + (ibe_pkg::AddrW + 1)'(2);
      st1_in.w8     = 1'b0;
      st1_in.w16    = 1'b0;
      if (req_mode_bits[ibe_pkg::MB_LDRR] && req_left_register == ibe_pkg::REG_MEMHL &&
          req_right_register == ibe_pkg::REG_MEMHL) begin
         st1_in.status = ibe_pkg::ST_MEM_MEM;
      end else begin
         st1_in.status = ibe_pkg::ST_OK;
      end
   end

   // stage 2: relative jumps measured from the end of the instruction
   always_comb begin
      st2_in = st1_ff;
      if (st1_ff.mode[ibe_pkg::MB_REL]) begin
         st2_in.imm = st1_ff.imm -
                      {{(ibe_pkg::ImmW - ibe_pkg::AddrW - 1){1'b0}}, st1_ff.addrp2};
      end
   end

   // stage 3: add <-> sub for a negative immediate, then the negate flag
   always_comb begin
      logic swap;
      st3_in = st2_ff;
      swap   = st2_ff.mode[ibe_pkg::MB_ADDSUB] && st2_ff.imm[ibe_pkg::ImmW-1];
      if (st2_ff.mode[ibe_pkg::MB_IMM]) begin
         if (swap) begin
            st3_in.enc = st2_ff.enc ^ ibe_pkg::OP_SWAP;
         end
         // two negations cancel
         if (swap ^ st2_ff.mode[ibe_pkg::MB_NEG]) begin
            st3_in.imm = ibe_pkg::ImmW'(0) - st2_ff.imm;
         end
      end
   end

   // stage 4: immediate byte count and the short high-page loads
   always_comb begin
      logic hp;
      st4_in = st3_ff;
      hp = !st3_ff.imm[ibe_pkg::ImmW-1] &&
           (st3_ff.imm[ibe_pkg::ImmW-2:0] >= (ibe_pkg::ImmW-1)'(ibe_pkg::HIGH_PAGE));
      if (st3_ff.mode[ibe_pkg::MB_IMM]) begin
         case (st3_ff.kind)
            ibe_pkg::KIND_UBYTE, ibe_pkg::KIND_SBYTE: st4_in.w8 = 1'b1;
            ibe_pkg::KIND_UWORD:                      st4_in.w16 = 1'b1;
            default: ;
         endcase
         if (hp && st3_ff.rnum == ibe_pkg::REG_A) begin
            st4_in.enc  = ibe_pkg::OP_LDH_TO;
            st4_in.imm  = {{(ibe_pkg::ImmW-8){1'b0}}, st3_ff.imm[7:0]};
            st4_in.rnum = 3'd0;
            st4_in.w8   = 1'b1;
            st4_in.w16  = 1'b0;
         end else if (hp && st3_ff.lnum == ibe_pkg::REG_A) begin
            st4_in.enc  = ibe_pkg::OP_LDH_FROM;
            st4_in.imm  = {{(ibe_pkg::ImmW-8){1'b0}}, st3_ff.imm[7:0]};
            st4_in.lnum = 3'd0;
            st4_in.w8   = 1'b1;
            st4_in.w16  = 1'b0;
         end
      end
   end

   // stage 5: range and restart checks, operand insertion, byte list
   always_comb begin
      logic signed [ibe_pkg::ImmW-1:0] imm_s;
      logic       bad;
      logic       rst;
      logic [2:0] status;
      logic [7:0] lsel;
      logic [7:0] op;
      logic [2:0] n;
      imm_s  = $signed(st4_ff.imm);
      rst    = st4_ff.mode[ibe_pkg::MB_RST];
      status = st4_ff.status;
      case (st4_ff.kind)
         ibe_pkg::KIND_BIT:   bad = imm_s < 0 || imm_s > 7;
         ibe_pkg::KIND_UBYTE: bad = imm_s < 0 || imm_s > 255;
         ibe_pkg::KIND_SBYTE: bad = imm_s < -128 || imm_s > 127;
         ibe_pkg::KIND_UWORD: bad = imm_s < 0 || imm_s > 65535;
         default:             bad = 1'b0;
      endcase
      if (status == ibe_pkg::ST_OK && st4_ff.mode[ibe_pkg::MB_IMM]) begin
         if (bad) begin
            status = st4_ff.mode[ibe_pkg::MB_REL] ? ibe_pkg::ST_JMP_RNG : ibe_pkg::ST_IMM_RNG;
         end else if (rst && (imm_s < 0 || imm_s > ibe_pkg::RST_MAX ||
                              st4_ff.imm[2:0] != 3'd0)) begin
            status = ibe_pkg::ST_BAD_RST;
         end
      end

      // the checked immediate stands in for the left operand of bit and rst
      if (st4_ff.mode[ibe_pkg::MB_IMM] &&
          (st4_ff.kind == ibe_pkg::KIND_BIT || rst)) begin
         lsel = st4_ff.imm[7:0];
      end else begin
         lsel = {5'd0, st4_ff.lnum};
      end
      op = st4_ff.enc;
      if (!st4_ff.lsh[3]) begin
         op = op | (lsel << st4_ff.lsh[2:0]);
      end
      if (!st4_ff.rsh[3]) begin
         op = op | ({5'd0, st4_ff.rnum} << st4_ff.rsh[2:0]);
      end

      ser_in.bytes = '0;
      n = 3'd0;
      if (st4_ff.mode[ibe_pkg::MB_PREFIX]) begin
         ser_in.bytes[n[1:0]] = ibe_pkg::OP_PREFIX;
         n = n + 3'd1;
      end
      ser_in.bytes[n[1:0]] = op;
      n = n + 3'd1;
      if (st4_ff.w16) begin
         ser_in.bytes[n[1:0]] = st4_ff.imm[7:0];
         n = n + 3'd1;
         ser_in.bytes[n[1:0]] = st4_ff.imm[15:8];
         n = n + 3'd1;
      end else if (st4_ff.w8) begin
         ser_in.bytes[n[1:0]] = st4_ff.imm[7:0];
         n = n + 3'd1;
      end else if (st4_ff.mode[ibe_pkg::MB_STOP]) begin
         ser_in.bytes[n[1:0]] = 8'h00;
         n = n + 3'd1;
      end
      ser_in.last_idx = 2'(n - 3'd1);
      ser_in.status   = status;

      // an error is a single zero byte carrying the status
      if (status != ibe_pkg::ST_OK) begin
         ser_in.bytes    = '0;
         ser_in.last_idx = 2'd0;
      end
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         ser_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         if (rdy[1]) vld_ff[1] <= accept;
         if (rdy[2]) vld_ff[2] <= vld_ff[1];
         if (rdy[3]) vld_ff[3] <= vld_ff[2];
         if (rdy[4]) vld_ff[4] <= vld_ff[3];
         if (ser_ready) begin
            ser_valid_ff <= vld_ff[4];
            idx_ff       <= 2'd0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (rdy[1]) st1_ff <= st1_in;
      if (rdy[2]) st2_ff <= st2_in;
      if (rdy[3]) st3_ff <= st3_in;
      if (rdy[4]) st4_ff <= st4_in;
      if (ser_ready) ser_ff <= ser_in;
   end

   // result ports straight from the serialiser
   assign rsp_strobe    = ser_valid_ff;
   assign rsp_out_byte  = ser_ff.bytes[idx_ff];
   assign rsp_last_byte = (idx_ff == ser_ff.last_idx);
   assign rsp_status    = ser_ff.status;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ibe_pkg::ST_OK |-> rsp_last_byte && rsp_out_byte == 8'h00)
      else $error("error result is not a single zero byte");

   a_bytes_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_byte |=> rsp_strobe && rsp_status == ibe_pkg::ST_OK)
      else $error("instruction bytes interrupted");

   a_busy_full: assert property (@(posedge clock) disable iff (reset)
      busy |-> vld_ff[1] && vld_ff[2] && vld_ff[3] && vld_ff[4] && ser_valid_ff)
      else $error("busy while the pipeline has room");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe && !busy)
      else $error("activity right after reset");

endmodule
